[rtl/core/itoa_pkg.sv]
package itoa_pkg;

    // top level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_XFER,
        ST_EMIT
    } top_state_t;

    // character emitter states
    typedef enum logic [1:0] {
        EM_IDLE,
        EM_TRIM,
        EM_SEND
    } emit_state_t;

    // control from the sequencer to the shift-add-3 converter
    typedef struct packed {
        logic load;
        logic step;
    } dab_ctrl_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

endpackage

[rtl/core/itoa_dabble.sv]
module itoa_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10
) (
    input  logic                    clk,
    input  itoa_pkg::dab_ctrl_t     ctrl,
    input  logic [VALUE_BITS-1:0]   value,
    output logic [NDIG*4-1:0]       bcd,
    output logic                    neg
);
    import itoa_pkg::*;

    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [NDIG*4-1:0]     bcd_reg;
    logic [NDIG*4-1:0]     bcd_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [NDIG*4-1:0]     adj;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // load magnitude, then shift one bit per step into the digits
    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        if (ctrl.load)
        begin
            neg_next = value[VALUE_BITS-1];
            mag_next = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
            bcd_next = '0;
        end
        else if (ctrl.step)
        begin
            bcd_next = {adj[NDIG*4-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign bcd = bcd_reg;
    assign neg = neg_reg;

endmodule

[rtl/core/itoa_emit.sv]
module itoa_emit #(
    parameter int NDIG = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               neg_in,
    input  logic [NDIG*4-1:0]  bcd_in,
    output logic               done,
    output logic               strobe,
    output logic [7:0]         out_char,
    output logic               last_char,
    output logic [3:0]         char_count
);
    import itoa_pkg::*;

    localparam int DCW = $clog2(NDIG + 1);
    localparam int SW  = (DCW + 1 > 4) ? DCW + 1 : 4;

    emit_state_t       state_reg;
    emit_state_t       state_next;
    logic [NDIG*4-1:0] bcd_reg;
    logic [NDIG*4-1:0] bcd_next;
    logic [DCW-1:0]    dcnt_reg;
    logic [DCW-1:0]    dcnt_next;
    logic              neg_reg;
    logic              neg_next;
    logic [3:0]        total_reg;
    logic [3:0]        total_next;
    logic [3:0]        top_digit;
    logic              lead_zero;
    logic              one_left;
    logic [SW-1:0]     total_sum;

    assign top_digit = bcd_reg[NDIG*4-1 -: 4];
    assign one_left  = (dcnt_reg == DCW'(1));
    assign lead_zero = (top_digit == 4'd0) && !one_left;
    assign total_sum = SW'(dcnt_reg) + SW'(neg_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (load)
                begin
                    state_next = EM_TRIM;
                end
            end
            EM_TRIM:
            begin
                if (!lead_zero)
                begin
                    state_next = EM_SEND;
                end
            end
            EM_SEND:
            begin
                if (!neg_reg && one_left)
                begin
                    state_next = EM_IDLE;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // datapath: drop leading zeros, then send one character per cycle
    always_comb
    begin
        bcd_next   = bcd_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        total_next = total_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (load)
                begin
                    bcd_next  = bcd_in;
                    dcnt_next = DCW'(NDIG);
                    neg_next  = neg_in;
                end
            end
            EM_TRIM:
            begin
                if (lead_zero)
                begin
                    bcd_next  = {bcd_reg[NDIG*4-5:0], 4'd0};
                    dcnt_next = dcnt_reg - DCW'(1);
                end
                else
                begin
                    total_next = total_sum[3:0];
                end
            end
            EM_SEND:
            begin
                if (neg_reg)
                begin
                    neg_next = 1'b0;
                end
                else
                begin
                    bcd_next  = {bcd_reg[NDIG*4-5:0], 4'd0};
                    dcnt_next = dcnt_reg - DCW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        strobe     = (state_reg == EM_SEND);
        done       = strobe && !neg_reg && one_left;
        char_count = total_reg;
        if (neg_reg)
        begin
            out_char  = CHAR_MINUS;
            last_char = 1'b0;
        end
        else
        begin
            out_char  = CHAR_ZERO + {4'd0, top_digit};
            last_char = one_left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        dcnt_reg  <= dcnt_next;
        neg_reg   <= neg_next;
        total_reg <= total_next;
    end

endmodule

[rtl/core/signed_int_to_decimal_ascii_unit.sv]
// signed integer to decimal ascii text
//
// input: raise start with a value while busy is low; the item is taken at
// that clock edge and busy stays high until its last character is out.
// output: each character appears for one cycle with strobe high, most
// significant first, a '-' ahead of the digits for a negative value.
// char_count holds the total text length on every character of an item and
// last_char marks the final one. the receiver cannot stall the output.
// conversion runs a shift-add-3 converter one magnitude bit per cycle,
// then drops leading zero digits one per cycle, then sends one character
// per cycle. the converter holds NDIG = 3*VALUE_BITS/10 + 1 digit slots,
// and the next item can be taken only after the last character of an
// item is out.
// reset clears the sequencers; the block then waits idle with busy low.
module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         busy,
    output logic                         strobe,
    output logic [7:0]                   out_char,
    output logic                         last_char,
    output logic [3:0]                   char_count
);
    import itoa_pkg::*;

    localparam int NDIG = (VALUE_BITS * 3) / 10 + 1;
    localparam int CW   = $clog2(VALUE_BITS);

    top_state_t        state_reg;
    top_state_t        state_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    dab_ctrl_t         dab_ctrl;
    logic              emit_load;
    logic              emit_done;
    logic [NDIG*4-1:0] bcd;
    logic              neg;
    logic              last_bit;

    assign last_bit = (cnt_reg == CW'(VALUE_BITS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (last_bit)
                begin
                    state_next = ST_XFER;
                end
            end
            ST_XFER:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and bit counter
    always_comb
    begin
        dab_ctrl  = '0;
        emit_load = 1'b0;
        cnt_next  = cnt_reg;
        busy      = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                dab_ctrl.load = start;
                cnt_next      = '0;
            end
            ST_CONV:
            begin
                dab_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + CW'(1);
            end
            ST_XFER:
            begin
                emit_load = 1'b1;
            end
            ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // binary to digits, one bit per cycle
    itoa_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .clk   (clk),
        .ctrl  (dab_ctrl),
        .value (value),
        .bcd   (bcd),
        .neg   (neg)
    );

    // digits to characters, one per cycle
    itoa_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit_load),
        .neg_in     (neg),
        .bcd_in     (bcd),
        .done       (emit_done),
        .strobe     (strobe),
        .out_char   (out_char),
        .last_char  (last_char),
        .char_count (char_count)
    );

    // characters only come out while an item is in flight
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("character strobe while idle");

    // nothing follows the last character of an item
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_char) |=> !strobe)
        else $error("strobe after last character");

    // characters of one item come back to back with one length
    a_count_held: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_char) |=> (strobe && $stable(char_count)))
        else $error("gap or length change inside an item");

    // every character is a minus sign or a decimal digit
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (out_char == CHAR_MINUS ||
                    (out_char >= CHAR_ZERO && out_char <= CHAR_NINE)))
        else $error("character out of range");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    import itoa_pkg::*;

    localparam int VALUE_BITS  = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 360;
    localparam int NUM_ROWS    = 22;
    localparam int DRAIN_CYCLES = 60;

    // one expected character of a number's text
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [3:0] count;
    } text_char_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic signed [VALUE_BITS-1:0] value;
    logic                         busy;
    logic                         strobe;
    logic [7:0]                   out_char;
    logic                         last_char;
    logic [3:0]                   char_count;

    text_char_t expected_chars[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;

    // directed items; an empty text means the predictor supplies it
    logic [VALUE_BITS-1:0] row_value [0:NUM_ROWS-1] = '{
        32'd0, 32'd1, -32'sd1, 32'd2147483647, 32'h8000_0000, -32'sd2147483647,
        32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
        32'd999999999, 32'd1000000000, -32'sd1000000000, 32'd1999999999,
        32'h5555_5555, 32'hAAAA_AAAA, 32'd12345, -32'sd12345, 32'd7, 32'h0000_FFFF
    };
    string row_text [0:NUM_ROWS-1] = '{
        "0", "1", "-1", "2147483647", "-2147483648", "-2147483647",
        "", "", "", "", "", "",
        "", "", "", "", "", "", "", "", "", ""
    };

    signed_int_to_decimal_ascii_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .busy       (busy),
        .strobe     (strobe),
        .out_char   (out_char),
        .last_char  (last_char),
        .char_count (char_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // decimal text of a signed value, magnitude taken as unsigned
    function automatic string decimal_text(logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        string                 txt;
        mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
        txt = "";
        do
        begin
            txt = $sformatf("%c%s", CHAR_ZERO + 8'(mag % 10), txt);
            mag = mag / 10;
        end
        while (mag != 0);
        if (v[VALUE_BITS-1])
        begin
            txt = $sformatf("%c%s", CHAR_MINUS, txt);
        end
        return txt;
    endfunction

    // queue every character of one number's text
    function automatic void queue_text(string txt);
        text_char_t c;
        for (int i = 0; i < txt.len(); i++)
        begin
            c.ch    = txt[i];
            c.last  = (i == txt.len() - 1);
            c.count = 4'(txt.len());
            expected_chars.push_back(c);
        end
    endfunction

    // random value: full range, small, by digit length, or near the extremes
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        longint                lo;
        longint                hi;
        int                    ndig;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 20);
            2:
            begin
                ndig = $urandom_range(1, 10);
                lo = 1;
                for (int i = 1; i < ndig; i++)
                begin
                    lo = lo * 10;
                end
                hi = lo * 10 - 1;
                if (ndig == 1)
                begin
                    lo = 0;
                end
                if (hi > 64'd2147483647)
                begin
                    hi = 64'd2147483647;
                end
                v = $urandom_range(32'(hi), 32'(lo));
            end
            default: v = $urandom_range(0, 3) + ($urandom_range(0, 1) ? 32'h7FFF_FFFC : 32'h0);
        endcase
        if ($urandom_range(0, 1))
        begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    // offer one item, with an optional idle burst ahead of it
    task automatic send_item(logic [VALUE_BITS-1:0] v, string txt, bit with_gaps);
        int gap;
        if (with_gaps && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        queue_text(txt);
    endtask

    // character checker
    always @(posedge clk)
    begin
        text_char_t exp_c;
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character: out_char %h", out_char);
                mismatch_count++;
            end
            else
            begin
                exp_c = expected_chars.pop_front();
                if (out_char !== exp_c.ch)
                begin
                    $error("out_char: expected %h, actual %h", exp_c.ch, out_char);
                    mismatch_count++;
                end
                if (last_char !== exp_c.last)
                begin
                    $error("last_char: expected %b, actual %b", exp_c.last, last_char);
                    mismatch_count++;
                end
                if (char_count !== exp_c.count)
                begin
                    $error("char_count: expected %0d, actual %0d", exp_c.count, char_count);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[signed_int_to_decimal_ascii_unit] ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [VALUE_BITS-1:0] v;
        rst_n <= 1'b0;
        start <= 1'b0;
        value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            send_item(row_value[r], (row_text[r] == "") ? decimal_text(row_value[r]) :
                      row_text[r], 1'b1);
        end

        // random items, idle bursts in the first two thirds only
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            v = random_value();
            send_item(v, decimal_text(v), n < (RANDOM_ITEMS * 2) / 3);
            // hold off until every character is out
            if (n == RANDOM_ITEMS / 3)
            begin
                start <= 1'b0;
                while (expected_chars.size() != 0)
                begin
                    @(posedge clk);
                end
            end
        end
        start <= 1'b0;

        // drain
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("[signed_int_to_decimal_ascii_unit] OK");
        end
        else
        begin
            $display("[signed_int_to_decimal_ascii_unit] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/itoa_pkg.sv
rtl/core/itoa_dabble.sv
rtl/core/itoa_emit.sv
rtl/core/signed_int_to_decimal_ascii_unit.sv
bench/testbench.sv
